### hw/rtl/i2cts_pkg.sv
// i2cts_pkg: shared constants, status and request kind codes, buffer slot function.
// Used by i2c_transfer_sequencer_top. No dependencies.
package i2cts_pkg;

   localparam int BUFFER_DEPTH = 128;
   localparam int BUF_AW       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

   localparam int REQ_DATA_W = 48;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USED_W = 25;

   // request kinds
   localparam logic [2:0] KIND_LOAD       = 3'd0;
   localparam logic [2:0] KIND_READ       = 3'd1;
   localparam logic [2:0] KIND_START_WR   = 3'd2;
   localparam logic [2:0] KIND_START_RD   = 3'd3;
   localparam logic [2:0] KIND_BUS_EVENT  = 3'd4;

   // status codes
   localparam logic [2:0] ST_ERROR  = 3'd0;
   localparam logic [2:0] ST_READY  = 3'd1;
   localparam logic [2:0] ST_HEADER = 3'd2;
   localparam logic [2:0] ST_XFER   = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   localparam logic [7:0] HDR_ADDR_MASK = 8'hFE;
   localparam logic [7:0] HDR_READ_BIT  = 8'h01;

   // Value modulo BUFFER_DEPTH: the depth is a power of two, so the low bits serve.
   function automatic logic [BUF_AW-1:0] buf_slot(input logic [7:0] value);
      return value[BUF_AW-1:0];
   endfunction

endpackage

### hw/rtl/i2cts_ram.sv
// i2cts_ram: generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module i2cts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/i2c_transfer_sequencer_top.sv
// i2c_transfer_sequencer_top: I2C byte transfer sequencer with byte buffer in RAM.
// Depends on i2cts_pkg and i2cts_ram.
//
// Usage:
//  - Request stream (req_*): one request per item; req_tuser carries the kind
//    (load buffer, read buffer, start master write/read, bus event), req_tdata
//    the remaining fields.
//  - Response stream (rsp_*): exactly one response per request, in order.
//  - Response path: an accepted request is registered in the RAM read stage,
//    then moves into the output register that drives rsp_tvalid.
//  - Throughput: one request per cycle while req_tready is high. Each request
//    does at most one buffer access (read or write) on the buffer RAM; the status
//    flags and counters update in the accept cycle, so the next request sees them
//    at once. RAM read data joins the response as it enters the output register.
//  - Stall: a two-entry pipe (RAM read stage plus output register) keeps
//    taking requests while a response waits; req_tready drops only when both
//    are full and rsp_tready is low.
//  - Reset: status ready, counters and flags cleared, length goal 1. The
//    buffer is not cleared; read an entry only after it was loaded.
module i2c_transfer_sequencer_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [6:0] buffer_index, [14:7] buffer_byte, [22:15] header_byte,
   // [30:23] transfer_length, [31] arbitration_lost, [32] ack_missing,
   // [33] byte_complete, [34] slave_read_requested, [42:35] received_byte
   input  logic [i2cts_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [2:0] kind
   input  logic [i2cts_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [2:0] status, [3] drive_valid, [11:4] drive_byte, [12] data_register_read,
   // [13] transmit_mode, [14] withhold_ack, [15] master_active,
   // [16] stop_generated, [24:17] buffer_data
   output logic [i2cts_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   import i2cts_pkg::*;

   typedef struct packed {
      logic [2:0] status;
      logic       dvalid;
      logic [7:0] dbyte;
      logic       dread;
      logic       tmode;
      logic       wack;
      logic       master;
      logic       stop;
      logic       drive_from_ram;
      logic       bdata_from_ram;
   } stage_type;

   // request fields
   logic [2:0] kind;
   logic [6:0] buffer_index;
   logic [7:0] buffer_byte;
   logic [7:0] header_byte;
   logic [7:0] transfer_length;
   logic       arbitration_lost;
   logic       ack_missing;
   logic       byte_complete;
   logic       slave_read_requested;
   logic [7:0] received_byte;

   assign kind                 = req_tuser[2:0];
   assign buffer_index         = req_tdata[6:0];
   assign buffer_byte          = req_tdata[14:7];
   assign header_byte          = req_tdata[22:15];
   assign transfer_length      = req_tdata[30:23];
   assign arbitration_lost     = req_tdata[31];
   assign ack_missing          = req_tdata[32];
   assign byte_complete        = req_tdata[33];
   assign slave_read_requested = req_tdata[34];
   assign received_byte        = req_tdata[42:35];

   // sequencer state
   logic [2:0] status_ff, status_in;
   logic       dir_tx_ff, dir_tx_in;
   logic [7:0] goal_ff, goal_in;
   logic [7:0] count_ff, count_in;
   logic       master_ff, master_in;
   logic       tx_ff, tx_in;
   logic       noack_ff, noack_in;

   // pipe
   logic                  s1_valid_ff, s1_valid_in;
   stage_type             s1_ff, s1_in;
   logic                  out_valid_ff, out_valid_in;
   logic [RSP_USED_W-1:0] out_data_ff, out_data_in;

   // buffer RAM
   logic              ram_wr_en;
   logic [BUF_AW-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic              ram_rd_en;
   logic [BUF_AW-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;

   logic accept;
   logic s1_move;

   assign s1_move    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_move;
   assign accept     = req_tvalid && req_tready;

   // request decode: flags update now, buffer access issued now
   always_comb begin
      logic       go;
      logic [8:0] count_p1;
      status_in   = status_ff;
      dir_tx_in   = dir_tx_ff;
      goal_in     = goal_ff;
      count_in    = count_ff;
      master_in   = master_ff;
      tx_in       = tx_ff;
      noack_in    = noack_ff;
      s1_in       = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = buf_slot({1'b0, buffer_index});
      ram_wr_data = buffer_byte;
      ram_rd_en   = 1'b0;
      ram_rd_addr = buf_slot({1'b0, buffer_index});
      go          = 1'b1;
      count_p1    = {1'b0, count_ff} + 9'd1;

      unique case (kind)
         KIND_LOAD: begin
            ram_wr_en = 1'b1;
         end
         KIND_READ: begin
            ram_rd_en = 1'b1;
            s1_in.bdata_from_ram = 1'b1;
         end
         KIND_START_WR, KIND_START_RD: begin
            goal_in      = transfer_length;
            count_in     = 8'd0;
            status_in    = ST_HEADER;
            dir_tx_in    = (kind == KIND_START_WR);
            noack_in     = 1'b0;
            tx_in        = 1'b1;
            master_in    = 1'b1;
            s1_in.dvalid = 1'b1;
            s1_in.dbyte  = (kind == KIND_START_WR) ? (header_byte & HDR_ADDR_MASK)
                                                   : ((header_byte & HDR_ADDR_MASK)
                                                      | HDR_READ_BIT);
         end
         KIND_BUS_EVENT: begin
            priority if (arbitration_lost) begin
               master_in = 1'b0;
               status_in = ST_ERROR;
            end else if (master_ff) begin
               priority if (ack_missing) begin
                  master_in = 1'b0;
                  status_in = ST_ERROR;
               end else if (status_ff == ST_DONE) begin
                  status_in  = ST_READY;
                  tx_in      = 1'b0;
                  master_in  = 1'b0;
                  s1_in.stop = 1'b1;
               end else if (status_ff == ST_HEADER || status_ff == ST_XFER) begin
                  if (status_ff == ST_HEADER) begin
                     tx_in     = dir_tx_ff;
                     status_in = ST_XFER;
                     if (!dir_tx_ff) begin
                        s1_in.dread = 1'b1;
                        go          = 1'b0;
                     end
                  end
                  if (go) begin
                     if (tx_in) begin
                        ram_rd_en            = 1'b1;
                        ram_rd_addr          = buf_slot(count_ff);
                        s1_in.dvalid         = 1'b1;
                        s1_in.drive_from_ram = 1'b1;
                     end else begin
                        if (count_p1 == {1'b0, goal_ff}) begin
                           noack_in = 1'b1;
                        end
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = buf_slot(count_ff);
                        ram_wr_data = received_byte;
                        s1_in.dread = 1'b1;
                     end
                     count_in = count_p1[7:0];
                     if (goal_ff <= count_p1[7:0]) begin
                        status_in = ST_DONE;
                     end
                  end
               end else begin
                  // idle master: error or ready, nothing changes
               end
            end else begin
               // slave side
               if (status_ff <= ST_READY) begin
                  status_in = ST_XFER;
                  tx_in     = slave_read_requested;
                  count_in  = 8'd1;
                  if (!slave_read_requested) begin
                     s1_in.dread = 1'b1;
                     go          = 1'b0;
                  end
               end
               if (go && byte_complete) begin
                  priority if (!tx_in) begin
                     ram_wr_en   = 1'b1;
                     ram_wr_addr = buf_slot(count_in);
                     ram_wr_data = received_byte;
                     s1_in.dread = 1'b1;
                     count_in    = count_in + 8'd1;
                  end else if (ack_missing) begin
                     tx_in       = 1'b0;
                     s1_in.dread = 1'b1;
                     status_in   = ST_READY;
                  end else begin
                     ram_rd_en            = 1'b1;
                     ram_rd_addr          = buf_slot(count_in);
                     s1_in.dvalid         = 1'b1;
                     s1_in.drive_from_ram = 1'b1;
                     count_in             = count_in + 8'd1;
                  end
               end
            end
         end
         default: begin
            // unused kinds: report current flags
         end
      endcase

      s1_in.status = status_in;
      s1_in.tmode  = tx_in;
      s1_in.wack   = noack_in;
      s1_in.master = master_in;

      if (!accept) begin
         ram_wr_en = 1'b0;
         ram_rd_en = 1'b0;
      end
   end

   // pipe control and response assembly
   always_comb begin
      logic [7:0] dbyte;
      logic [7:0] bdata;
      dbyte        = s1_ff.drive_from_ram ? ram_rd_data : s1_ff.dbyte;
      bdata        = s1_ff.bdata_from_ram ? ram_rd_data : 8'd0;
      s1_valid_in  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_move ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      out_data_in  = s1_move ? {bdata, s1_ff.stop, s1_ff.master, s1_ff.wack, s1_ff.tmode,
                                s1_ff.dread, dbyte, s1_ff.dvalid, s1_ff.status}
                             : out_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= ST_READY;
         dir_tx_ff    <= 1'b0;
         goal_ff      <= 8'd1;
         count_ff     <= 8'd0;
         master_ff    <= 1'b0;
         tx_ff        <= 1'b0;
         noack_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            status_ff <= status_in;
            dir_tx_ff <= dir_tx_in;
            goal_ff   <= goal_in;
            count_ff  <= count_in;
            master_ff <= master_in;
            tx_ff     <= tx_in;
            noack_ff  <= noack_in;
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_USED_W){1'b0}}, out_data_ff};

   i2cts_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_DEPTH)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

### tb/i2c_transfer_sequencer_checker.sv
`timescale 1ns / 100ps
// i2c_transfer_sequencer_checker: watches the request and response streams of the
// I2C transfer sequencer, predicts every response and compares it field by field.
// Depends on i2cts_pkg for kind and status codes and the buffer depth.
module i2c_transfer_sequencer_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [i2cts_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [i2cts_pkg::REQ_USER_W-1:0]  req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [i2cts_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output int                                fail_count,
   output int                                outstanding
);
   import i2cts_pkg::*;

   localparam int MAX_PRINTED = 200;

   typedef struct packed {
      logic [4:0] pad;
      logic [7:0] rx_byte;
      logic       slave_read;
      logic       byte_done;
      logic       ack_missing;
      logic       arb_lost;
      logic [7:0] length;
      logic [7:0] header;
      logic [7:0] load_byte;
      logic [6:0] index;
   } request_type;

   typedef struct packed {
      logic [6:0] pad;
      logic [7:0] buffer_data;
      logic       stop_generated;
      logic       master_active;
      logic       withhold_ack;
      logic       transmit_mode;
      logic       data_register_read;
      logic [7:0] drive_byte;
      logic       drive_valid;
      logic [2:0] status;
   } response_type;

   // shadow of the sequencer state
   logic [2:0] seq_status;
   logic       dir_tx;
   logic [7:0] goal_len;
   logic [7:0] count;
   logic       is_master;
   logic       tx_mode;
   logic       hold_ack;
   logic [7:0] shadow_buf [BUFFER_DEPTH];

   response_type  awaited_replies [$];
   response_type  predicted;
   response_type  oldest;
   response_type  observed;
   int            accepted_reqs;
   int            accepted_rsps;

   initial fail_count = 0;
   assign outstanding = accepted_reqs - accepted_rsps;

   function automatic int ring_slot(input logic [7:0] value);
      return int'(value) % BUFFER_DEPTH;
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < MAX_PRINTED) begin
         $display("%0t ns: mismatch: %s", $time, msg);
      end
      fail_count++;
   endtask

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         report_mismatch($sformatf("%s expected 0x%02h got 0x%02h", name, want, got));
      end
   endtask

   task automatic step_sequencer(input logic [2:0] kind, input request_type rq,
                                 output response_type rs);
      logic go;
      rs = '0;
      go = 1'b1;
      case (kind)
         KIND_LOAD: begin
            shadow_buf[ring_slot({1'b0, rq.index})] = rq.load_byte;
         end
         KIND_READ: begin
            rs.buffer_data = shadow_buf[ring_slot({1'b0, rq.index})];
         end
         KIND_START_WR, KIND_START_RD: begin
            goal_len   = rq.length;
            count      = 8'd0;
            seq_status = ST_HEADER;
            dir_tx     = (kind == KIND_START_WR);
            hold_ack   = 1'b0;
            tx_mode    = 1'b1;
            is_master  = 1'b1;
            rs.drive_valid = 1'b1;
            rs.drive_byte  = (rq.header & HDR_ADDR_MASK) | (dir_tx ? 8'h00 : HDR_READ_BIT);
         end
         KIND_BUS_EVENT: begin
            if (rq.arb_lost) begin
               is_master  = 1'b0;
               seq_status = ST_ERROR;
            end else if (is_master) begin
               if (rq.ack_missing) begin
                  is_master  = 1'b0;
                  seq_status = ST_ERROR;
               end else if (seq_status == ST_DONE) begin
                  seq_status = ST_READY;
                  tx_mode    = 1'b0;
                  is_master  = 1'b0;
                  rs.stop_generated = 1'b1;
               end else if (seq_status == ST_HEADER || seq_status == ST_XFER) begin
                  if (seq_status == ST_HEADER) begin
                     tx_mode    = dir_tx;
                     seq_status = ST_XFER;
                     // read: header phase only releases the bus
                     if (!tx_mode) begin
                        rs.data_register_read = 1'b1;
                        go = 1'b0;
                     end
                  end
                  if (go) begin
                     if (tx_mode) begin
                        rs.drive_valid = 1'b1;
                        rs.drive_byte  = shadow_buf[ring_slot(count)];
                     end else begin
                        if ({1'b0, count} + 9'd1 == {1'b0, goal_len}) hold_ack = 1'b1;
                        shadow_buf[ring_slot(count)] = rq.rx_byte;
                        rs.data_register_read = 1'b1;
                     end
                     count = count + 8'd1;
                     if (goal_len <= count) seq_status = ST_DONE;
                  end
               end
            end else begin
               // slave: first event after error or ready sets up the transfer
               if (seq_status <= ST_READY) begin
                  seq_status = ST_XFER;
                  tx_mode    = rq.slave_read;
                  count      = 8'd1;
                  if (!tx_mode) begin
                     rs.data_register_read = 1'b1;
                     go = 1'b0;
                  end
               end
               if (go && rq.byte_done) begin
                  if (!tx_mode) begin
                     shadow_buf[ring_slot(count)] = rq.rx_byte;
                     rs.data_register_read = 1'b1;
                     count = count + 8'd1;
                  end else if (rq.ack_missing) begin
                     tx_mode    = 1'b0;
                     seq_status = ST_READY;
                     rs.data_register_read = 1'b1;
                  end else begin
                     rs.drive_valid = 1'b1;
                     rs.drive_byte  = shadow_buf[ring_slot(count)];
                     count = count + 8'd1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      rs.status        = seq_status;
      rs.transmit_mode = tx_mode;
      rs.withhold_ack  = hold_ack;
      rs.master_active = is_master;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         seq_status    = ST_READY;
         dir_tx        = 1'b0;
         goal_len      = 8'd1;
         count         = 8'd0;
         is_master     = 1'b0;
         tx_mode       = 1'b0;
         hold_ack      = 1'b0;
         awaited_replies.delete();
         accepted_reqs <= 0;
         accepted_rsps <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            step_sequencer(req_tuser, req_tdata, predicted);
            awaited_replies.push_back(predicted);
            accepted_reqs <= accepted_reqs + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            accepted_rsps <= accepted_rsps + 1;
            if (awaited_replies.size() == 0) begin
               report_mismatch("response with no request waiting");
            end else begin
               oldest   = awaited_replies.pop_front();
               observed = rsp_tdata;
               compare_field("status", 8'(oldest.status), 8'(observed.status));
               compare_field("drive_valid", 8'(oldest.drive_valid), 8'(observed.drive_valid));
               compare_field("drive_byte", oldest.drive_byte, observed.drive_byte);
               compare_field("data_register_read", 8'(oldest.data_register_read),
                             8'(observed.data_register_read));
               compare_field("transmit_mode", 8'(oldest.transmit_mode),
                             8'(observed.transmit_mode));
               compare_field("withhold_ack", 8'(oldest.withhold_ack),
                             8'(observed.withhold_ack));
               compare_field("master_active", 8'(oldest.master_active),
                             8'(observed.master_active));
               compare_field("stop_generated", 8'(oldest.stop_generated),
                             8'(observed.stop_generated));
               compare_field("buffer_data", oldest.buffer_data, observed.buffer_data);
            end
         end
      end
   end

endmodule

### tb/i2c_transfer_sequencer_top_tb.sv
`timescale 1ns / 100ps
// i2c_transfer_sequencer_top_tb: stimulus and verdict for the I2C transfer sequencer.
// Depends on i2cts_pkg, i2c_transfer_sequencer_top and i2c_transfer_sequencer_checker.
module i2c_transfer_sequencer_top_tb;
   import i2cts_pkg::*;

   localparam int CLK_PERIOD   = 10;
   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_ITEMS = 1740;
   // extra cycles at the end to catch stray responses
   localparam int DRAIN_CYCLES = 8;
   localparam int TIMEOUT_NS   = 2_000_000;

   // kinds the block ignores
   localparam logic [2:0] KIND_UNUSED_LO = 3'd5;
   localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

   // request field layout, lowest bits last
   typedef struct packed {
      logic [4:0] pad;
      logic [7:0] rx_byte;
      logic       slave_read;
      logic       byte_done;
      logic       ack_missing;
      logic       arb_lost;
      logic [7:0] length;
      logic [7:0] header;
      logic [7:0] load_byte;
      logic [6:0] index;
   } request_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic [REQ_USER_W-1:0]   req_tuser  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;

   int fail_count;
   int outstanding;
   int send_idle;   // percent of cycles the request side holds off
   int rcv_idle;    // percent of cycles the response side stalls
   int items_sent;

   always #(CLK_PERIOD / 2) clock = ~clock;

   i2c_transfer_sequencer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   i2c_transfer_sequencer_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // Response backpressure: fresh random decision every cycle.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rcv_idle);
   end

   // All fields random, pad bits zero.
   function automatic request_type random_fields();
      logic [63:0] r;
      request_type f;
      r = {$urandom(), $urandom()};
      f = r[REQ_DATA_W-1:0];
      f.pad = '0;
      return f;
   endfunction

   // Bus event with the given flags; the rest stays random.
   function automatic request_type bus_fields(input logic arb, input logic nack,
                                              input logic done, input logic srd);
      request_type f;
      f = random_fields();
      f.arb_lost    = arb;
      f.ack_missing = nack;
      f.byte_done   = done;
      f.slave_read  = srd;
      return f;
   endfunction

   // One request: optional random hold-off, then hold valid until accepted.
   // Valid stays high into the next request when no hold-off is drawn, so
   // back-to-back requests never lower and raise it in the same step.
   task automatic send_req(input logic [2:0] kind, input request_type f);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= f;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Hold the request side until every predicted response has come back.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding > 0) @(posedge clock);
   endtask

   initial begin
      request_type f;
      int       n;
      int       pick;
      int       phase_end;
      logic     srd;
      logic [2:0] start_kind;
      logic [7:0] len;

      send_idle  = 6;
      rcv_idle   = 56;
      items_sent = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Fill the whole buffer first: every slot a transfer or read can reach
      // is then defined. Slot 0 gets all zeros, the top slot all ones.
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
         f = random_fields();
         f.index = 7'(i);
         if (i == 0) f.load_byte = 8'h00;
         if (i == BUFFER_DEPTH - 1) f.load_byte = 8'hFF;
         send_req(KIND_LOAD, f);
      end

      // --- directed part ---
      // read back both ends of the buffer
      f = random_fields();
      f.index = 7'h00;
      send_req(KIND_READ, f);
      f.index = 7'h7F;
      send_req(KIND_READ, f);

      // reserved kinds change nothing
      for (int k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI; k++) begin
         send_req(3'(k), random_fields());
      end

      // master write, all-ones header, two bytes, then the stop event
      f = random_fields();
      f.header = 8'hFF;
      f.length = 8'd2;
      send_req(KIND_START_WR, f);
      repeat (3) send_req(KIND_BUS_EVENT,
                          bus_fields(1'b0, 1'b0, 1'($urandom), 1'($urandom)));

      // master read, zero header, one byte: ack withheld on that byte
      f = random_fields();
      f.header = 8'h00;
      f.length = 8'd1;
      send_req(KIND_START_RD, f);
      send_req(KIND_BUS_EVENT, bus_fields(1'b0, 1'b0, 1'($urandom), 1'($urandom)));
      f = bus_fields(1'b0, 1'b0, 1'($urandom), 1'($urandom));
      f.rx_byte = 8'hFF;
      send_req(KIND_BUS_EVENT, f);
      send_req(KIND_BUS_EVENT, bus_fields(1'b0, 1'b0, 1'($urandom), 1'($urandom)));

      // missing acknowledge while master -> error
      f = random_fields();
      f.length = 8'd3;
      send_req(KIND_START_WR, f);
      send_req(KIND_BUS_EVENT, bus_fields(1'b0, 1'b1, 1'($urandom), 1'($urandom)));

      // arbitration loss, checked even when not master
      send_req(KIND_BUS_EVENT, bus_fields(1'b1, 1'b0, 1'($urandom), 1'($urandom)));

      // slave transmit from slot 1, then master nack returns to ready
      send_req(KIND_BUS_EVENT, bus_fields(1'b0, 1'b0, 1'b1, 1'b1));
      send_req(KIND_BUS_EVENT, bus_fields(1'b0, 1'b1, 1'b1, 1'b1));

      // slave receive: setup, one byte stored, event without byte complete
      send_req(KIND_BUS_EVENT, bus_fields(1'b0, 1'b0, 1'b1, 1'b0));
      f = bus_fields(1'b0, 1'b0, 1'b1, 1'b0);
      f.rx_byte = 8'h00;
      send_req(KIND_BUS_EVENT, f);
      send_req(KIND_BUS_EVENT, bus_fields(1'b0, 1'b0, 1'b0, 1'b0));

      // zero length write: done right after the header event
      f = random_fields();
      f.length = 8'd0;
      send_req(KIND_START_WR, f);
      repeat (2) send_req(KIND_BUS_EVENT,
                          bus_fields(1'b0, 1'b0, 1'($urandom), 1'($urandom)));

      drain_responses();

      // --- random part, three backpressure phases ---
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle = 6;
               rcv_idle  = 56;
            end
            1: begin
               send_idle = 56;
               rcv_idle  = 6;
            end
            default: begin
               send_idle = 0;
               rcv_idle  = 0;
            end
         endcase
         phase_end = items_sent + RANDOM_ITEMS / 3;

         while (items_sent < phase_end) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
               // well-formed master transfer: start, byte events, stop event
               start_kind = (pick < 35) ? KIND_START_WR : KIND_START_RD;
               n = $urandom_range(99);
               if (n < 5) len = 8'd0;
               else if (n < 7) len = 8'($urandom_range(255, 64));
               else len = 8'($urandom_range(6, 1));
               f = random_fields();
               f.length = len;
               send_req(start_kind, f);
               // read needs one extra event for the header phase
               n = int'(len) + ((start_kind == KIND_START_WR) ? 1 : 2)
                   + $urandom_range(1);
               repeat (n) begin
                  if ($urandom_range(99) < 10) begin
                     send_req(($urandom_range(1) == 1) ? KIND_READ : KIND_LOAD,
                              random_fields());
                  end
                  send_req(KIND_BUS_EVENT,
                           bus_fields($urandom_range(199) == 0, $urandom_range(99) < 2,
                                      1'($urandom), 1'($urandom)));
               end
            end else if (pick < 85) begin
               // slave transfer in one direction
               srd = 1'($urandom_range(1));
               repeat ($urandom_range(8, 2)) begin
                  send_req(KIND_BUS_EVENT,
                           bus_fields($urandom_range(99) == 0, $urandom_range(99) < 10,
                                      $urandom_range(99) < 85, srd));
               end
            end else begin
               // noise, any kind and any content
               repeat ($urandom_range(4, 1)) begin
                  send_req(3'($urandom_range(KIND_UNUSED_HI, KIND_LOAD)), random_fields());
               end
            end
         end

         drain_responses();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Hard stop if responses never come back.
   initial begin
      #(TIMEOUT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### filelist.f
hw/rtl/i2cts_pkg.sv
hw/rtl/i2cts_ram.sv
hw/rtl/i2c_transfer_sequencer_top.sv
tb/i2c_transfer_sequencer_checker.sv
tb/i2c_transfer_sequencer_top_tb.sv
